[sv/rvdec_pkg.sv]
// Package for the RV32I instruction decoder: word types, operation codes,
// major opcodes and function-field codes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rvdec_pkg;

  // Input word: one instruction and the address it came from.
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] fetch_address;
  } in_word_t;

  // Result word: decoded fields plus the echoed input.
  typedef struct packed {
    logic [5:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic [31:0]        instr_echo;
    logic [31:0]        addr_echo;
  } out_word_t;

  // Dense operation codes.
  localparam logic [5:0] OP_ADD     = 6'd0;
  localparam logic [5:0] OP_SUB     = 6'd1;
  localparam logic [5:0] OP_SLL     = 6'd2;
  localparam logic [5:0] OP_SRL     = 6'd3;
  localparam logic [5:0] OP_SRA     = 6'd4;
  localparam logic [5:0] OP_SLT     = 6'd5;
  localparam logic [5:0] OP_SLTU    = 6'd6;
  localparam logic [5:0] OP_AND     = 6'd7;
  localparam logic [5:0] OP_OR      = 6'd8;
  localparam logic [5:0] OP_XOR     = 6'd9;
  localparam logic [5:0] OP_ADDI    = 6'd10;
  localparam logic [5:0] OP_SLLI    = 6'd11;
  localparam logic [5:0] OP_SRLI    = 6'd12;
  localparam logic [5:0] OP_SRAI    = 6'd13;
  localparam logic [5:0] OP_SLTI    = 6'd14;
  localparam logic [5:0] OP_SLTIU   = 6'd15;
  localparam logic [5:0] OP_ANDI    = 6'd16;
  localparam logic [5:0] OP_ORI     = 6'd17;
  localparam logic [5:0] OP_XORI    = 6'd18;
  localparam logic [5:0] OP_LB      = 6'd19;
  localparam logic [5:0] OP_LH      = 6'd20;
  localparam logic [5:0] OP_LW      = 6'd21;
  localparam logic [5:0] OP_LBU     = 6'd22;
  localparam logic [5:0] OP_LHU     = 6'd23;
  localparam logic [5:0] OP_SB      = 6'd24;
  localparam logic [5:0] OP_SH      = 6'd25;
  localparam logic [5:0] OP_SW      = 6'd26;
  localparam logic [5:0] OP_BEQ     = 6'd27;
  localparam logic [5:0] OP_BNE     = 6'd28;
  localparam logic [5:0] OP_BLT     = 6'd29;
  localparam logic [5:0] OP_BGE     = 6'd30;
  localparam logic [5:0] OP_BLTU    = 6'd31;
  localparam logic [5:0] OP_BGEU    = 6'd32;
  localparam logic [5:0] OP_JAL     = 6'd33;
  localparam logic [5:0] OP_JALR    = 6'd34;
  localparam logic [5:0] OP_LUI     = 6'd35;
  localparam logic [5:0] OP_AUIPC   = 6'd36;
  localparam logic [5:0] OP_ECALL   = 6'd37;
  localparam logic [5:0] OP_EBREAK  = 6'd38;
  localparam logic [5:0] OP_FENCE   = 6'd39;
  localparam logic [5:0] OP_ILLEGAL = 6'd40;

  // Major opcodes (instruction bits 6:0).
  localparam logic [6:0] MAJOR_LUI    = 7'h37;
  localparam logic [6:0] MAJOR_AUIPC  = 7'h17;
  localparam logic [6:0] MAJOR_JAL    = 7'h6f;
  localparam logic [6:0] MAJOR_JALR   = 7'h67;
  localparam logic [6:0] MAJOR_BRANCH = 7'h63;
  localparam logic [6:0] MAJOR_LOAD   = 7'h03;
  localparam logic [6:0] MAJOR_STORE  = 7'h23;
  localparam logic [6:0] MAJOR_OP_IMM = 7'h13;
  localparam logic [6:0] MAJOR_OP     = 7'h33;
  localparam logic [6:0] MAJOR_FENCE  = 7'h0f;
  localparam logic [6:0] MAJOR_SYSTEM = 7'h73;

  // funct3 codes of the ALU groups.
  localparam logic [2:0] F3_ADD  = 3'b000;
  localparam logic [2:0] F3_SLL  = 3'b001;
  localparam logic [2:0] F3_SLT  = 3'b010;
  localparam logic [2:0] F3_SLTU = 3'b011;
  localparam logic [2:0] F3_XOR  = 3'b100;
  localparam logic [2:0] F3_SR   = 3'b101;
  localparam logic [2:0] F3_OR   = 3'b110;
  localparam logic [2:0] F3_AND  = 3'b111;

  // funct3 codes of branches.
  localparam logic [2:0] F3_BEQ  = 3'b000;
  localparam logic [2:0] F3_BNE  = 3'b001;
  localparam logic [2:0] F3_BLT  = 3'b100;
  localparam logic [2:0] F3_BGE  = 3'b101;
  localparam logic [2:0] F3_BLTU = 3'b110;
  localparam logic [2:0] F3_BGEU = 3'b111;

  // funct3 codes of loads and stores.
  localparam logic [2:0] F3_B  = 3'b000;
  localparam logic [2:0] F3_H  = 3'b001;
  localparam logic [2:0] F3_W  = 3'b010;
  localparam logic [2:0] F3_BU = 3'b100;
  localparam logic [2:0] F3_HU = 3'b101;

  // funct3 of JALR.
  localparam logic [2:0] F3_JALR = 3'b000;

  // funct7 codes.
  localparam logic [6:0] F7_NORMAL    = 7'h00;
  localparam logic [6:0] F7_ALTERNATE = 7'h20;

  // SYSTEM function codes (bits 31:20).
  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;

endpackage

`default_nettype wire

[sv/rv32i_instruction_decoder.sv]
// RV32I instruction decoder: input register, decode logic, result register.
// Depends on rvdec_pkg for the word types and the operation codes.
//
//  Channel  Ports                     Handshake
//  -------  ------------------------  -----------------------------------------
//  input    start, busy, in_data      word taken at a clock edge with start=1
//                                     and busy=0
//  result   out_valid, out_data       out_valid high for one cycle per word
//
// An accepted word is first loaded into the input register; the result
// register then loads its decoded result from the decode logic.
// One word is accepted every cycle; the decode logic is a single shallow
// pass and busy is always low. The receiver cannot stall, so every result
// is shown for exactly one cycle. A synchronous active-low reset clears the
// two valid flags; the payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_instruction_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire rvdec_pkg::in_word_t in_data,
  output logic                     out_valid,
  output rvdec_pkg::out_word_t     out_data
);

  // Input register stage.
  logic                in_vld_r;
  logic                in_vld_nxt;
  rvdec_pkg::in_word_t in_data_r;

  // Result register stage.
  logic                 out_vld_r;
  rvdec_pkg::out_word_t out_data_r;
  rvdec_pkg::out_word_t out_data_nxt;

  // Instruction fields of the word held in the input register.
  logic [31:0] w;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] imm_shamt;

  // The decoder never holds a word back.
  assign busy = 1'b0;

  assign in_vld_nxt = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= in_vld_r;
    end
  end

  // Payload registers load with their stage and need no reset.
  always_ff @(posedge clk) begin
    if (in_vld_nxt) begin
      in_data_r <= in_data;
    end
    if (in_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign w   = in_data_r.instr_word;
  assign opc = w[6:0];
  assign f3  = w[14:12];
  assign f7  = w[31:25];

  // Immediates of each format, widened to 32 bits; the shift amount is zero-extended.
  assign imm_i     = {{20{w[31]}}, w[31:20]};
  assign imm_s     = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b     = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j     = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign imm_u     = {w[31:12], 12'h000};
  assign imm_shamt = {27'd0, w[24:20]};

  // Decode. The defaults are those of an unknown opcode: illegal, raw
  // register fields and a zero immediate. Each format then overrides the
  // fields it defines, and the register fields it does not use are zeroed.
  always_comb begin
    out_data_nxt.operation  = rvdec_pkg::OP_ILLEGAL;
    out_data_nxt.dest_reg   = w[11:7];
    out_data_nxt.src_reg_a  = w[19:15];
    out_data_nxt.src_reg_b  = w[24:20];
    out_data_nxt.immediate  = '0;
    out_data_nxt.instr_echo = w;
    out_data_nxt.addr_echo  = in_data_r.fetch_address;

    case (opc)
      rvdec_pkg::MAJOR_LUI: begin
        out_data_nxt.operation = rvdec_pkg::OP_LUI;
        out_data_nxt.immediate = imm_u;
        out_data_nxt.src_reg_a = '0;
        out_data_nxt.src_reg_b = '0;
      end
      rvdec_pkg::MAJOR_AUIPC: begin
        out_data_nxt.operation = rvdec_pkg::OP_AUIPC;
        out_data_nxt.immediate = imm_u;
        out_data_nxt.src_reg_a = '0;
        out_data_nxt.src_reg_b = '0;
      end
      rvdec_pkg::MAJOR_JAL: begin
        out_data_nxt.operation = rvdec_pkg::OP_JAL;
        out_data_nxt.immediate = imm_j;
        out_data_nxt.src_reg_a = '0;
        out_data_nxt.src_reg_b = '0;
      end
      rvdec_pkg::MAJOR_JALR: begin
        // A bad funct3 leaves the whole word undecoded.
        if (f3 == rvdec_pkg::F3_JALR) begin
          out_data_nxt.operation = rvdec_pkg::OP_JALR;
          out_data_nxt.immediate = imm_i;
          out_data_nxt.src_reg_b = '0;
        end
      end
      rvdec_pkg::MAJOR_BRANCH: begin
        out_data_nxt.immediate = imm_b;
        out_data_nxt.dest_reg  = '0;
        case (f3)
          rvdec_pkg::F3_BEQ:  out_data_nxt.operation = rvdec_pkg::OP_BEQ;
          rvdec_pkg::F3_BNE:  out_data_nxt.operation = rvdec_pkg::OP_BNE;
          rvdec_pkg::F3_BLT:  out_data_nxt.operation = rvdec_pkg::OP_BLT;
          rvdec_pkg::F3_BGE:  out_data_nxt.operation = rvdec_pkg::OP_BGE;
          rvdec_pkg::F3_BLTU: out_data_nxt.operation = rvdec_pkg::OP_BLTU;
          rvdec_pkg::F3_BGEU: out_data_nxt.operation = rvdec_pkg::OP_BGEU;
          default:            out_data_nxt.operation = rvdec_pkg::OP_ILLEGAL;
        endcase
      end
      rvdec_pkg::MAJOR_LOAD: begin
        out_data_nxt.immediate = imm_i;
        out_data_nxt.src_reg_b = '0;
        case (f3)
          rvdec_pkg::F3_B:  out_data_nxt.operation = rvdec_pkg::OP_LB;
          rvdec_pkg::F3_H:  out_data_nxt.operation = rvdec_pkg::OP_LH;
          rvdec_pkg::F3_W:  out_data_nxt.operation = rvdec_pkg::OP_LW;
          rvdec_pkg::F3_BU: out_data_nxt.operation = rvdec_pkg::OP_LBU;
          rvdec_pkg::F3_HU: out_data_nxt.operation = rvdec_pkg::OP_LHU;
          default:          out_data_nxt.operation = rvdec_pkg::OP_ILLEGAL;
        endcase
      end
      rvdec_pkg::MAJOR_STORE: begin
        out_data_nxt.immediate = imm_s;
        out_data_nxt.dest_reg  = '0;
        case (f3)
          rvdec_pkg::F3_B: out_data_nxt.operation = rvdec_pkg::OP_SB;
          rvdec_pkg::F3_H: out_data_nxt.operation = rvdec_pkg::OP_SH;
          rvdec_pkg::F3_W: out_data_nxt.operation = rvdec_pkg::OP_SW;
          default:         out_data_nxt.operation = rvdec_pkg::OP_ILLEGAL;
        endcase
      end
      rvdec_pkg::MAJOR_OP_IMM: begin
        out_data_nxt.immediate = imm_i;
        out_data_nxt.src_reg_b = '0;
        case (f3)
          rvdec_pkg::F3_ADD:  out_data_nxt.operation = rvdec_pkg::OP_ADDI;
          rvdec_pkg::F3_SLT:  out_data_nxt.operation = rvdec_pkg::OP_SLTI;
          rvdec_pkg::F3_SLTU: out_data_nxt.operation = rvdec_pkg::OP_SLTIU;
          rvdec_pkg::F3_XOR:  out_data_nxt.operation = rvdec_pkg::OP_XORI;
          rvdec_pkg::F3_OR:   out_data_nxt.operation = rvdec_pkg::OP_ORI;
          rvdec_pkg::F3_AND:  out_data_nxt.operation = rvdec_pkg::OP_ANDI;
          rvdec_pkg::F3_SLL: begin
            // A shift with a bad upper field keeps the full I immediate.
            if (f7 == rvdec_pkg::F7_NORMAL) begin
              out_data_nxt.operation = rvdec_pkg::OP_SLLI;
              out_data_nxt.immediate = imm_shamt;
            end
          end
          default: begin
            if (f7 == rvdec_pkg::F7_NORMAL) begin
              out_data_nxt.operation = rvdec_pkg::OP_SRLI;
              out_data_nxt.immediate = imm_shamt;
            end else if (f7 == rvdec_pkg::F7_ALTERNATE) begin
              out_data_nxt.operation = rvdec_pkg::OP_SRAI;
              out_data_nxt.immediate = imm_shamt;
            end
          end
        endcase
      end
      rvdec_pkg::MAJOR_OP: begin
        // Register fields stay raw; only the operation depends on funct3/7.
        if (f7 == rvdec_pkg::F7_NORMAL) begin
          case (f3)
            rvdec_pkg::F3_ADD:  out_data_nxt.operation = rvdec_pkg::OP_ADD;
            rvdec_pkg::F3_SLL:  out_data_nxt.operation = rvdec_pkg::OP_SLL;
            rvdec_pkg::F3_SLT:  out_data_nxt.operation = rvdec_pkg::OP_SLT;
            rvdec_pkg::F3_SLTU: out_data_nxt.operation = rvdec_pkg::OP_SLTU;
            rvdec_pkg::F3_XOR:  out_data_nxt.operation = rvdec_pkg::OP_XOR;
            rvdec_pkg::F3_SR:   out_data_nxt.operation = rvdec_pkg::OP_SRL;
            rvdec_pkg::F3_OR:   out_data_nxt.operation = rvdec_pkg::OP_OR;
            default:            out_data_nxt.operation = rvdec_pkg::OP_AND;
          endcase
        end else if (f7 == rvdec_pkg::F7_ALTERNATE) begin
          case (f3)
            rvdec_pkg::F3_ADD: out_data_nxt.operation = rvdec_pkg::OP_SUB;
            rvdec_pkg::F3_SR:  out_data_nxt.operation = rvdec_pkg::OP_SRA;
            default:           out_data_nxt.operation = rvdec_pkg::OP_ILLEGAL;
          endcase
        end
      end
      rvdec_pkg::MAJOR_FENCE: begin
        // Every FENCE encoding is accepted; its fields are not reported.
        out_data_nxt.operation = rvdec_pkg::OP_FENCE;
        out_data_nxt.dest_reg  = '0;
        out_data_nxt.src_reg_a = '0;
        out_data_nxt.src_reg_b = '0;
      end
      rvdec_pkg::MAJOR_SYSTEM: begin
        // Only the upper twelve bits select the call; the rest are ignored.
        out_data_nxt.dest_reg  = '0;
        out_data_nxt.src_reg_a = '0;
        out_data_nxt.src_reg_b = '0;
        if (w[31:20] == rvdec_pkg::SYS_ECALL) begin
          out_data_nxt.operation = rvdec_pkg::OP_ECALL;
        end else if (w[31:20] == rvdec_pkg::SYS_EBREAK) begin
          out_data_nxt.operation = rvdec_pkg::OP_EBREAK;
        end
      end
      default: begin
        out_data_nxt.operation = rvdec_pkg::OP_ILLEGAL;
      end
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // An accepted word's result strobe follows once the word has passed the input and result registers.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing two cycles after acceptance");

  // No result without a word previously held in the input register.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_vld_r))
    else $error("result strobe without a word in the input stage");

  // Operation codes never exceed the illegal code.
  a_op_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.operation <= rvdec_pkg::OP_ILLEGAL))
    else $error("operation code out of range");

  // Shift-immediate results carry only a five-bit shift amount.
  a_shamt_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.operation == rvdec_pkg::OP_SLLI ||
                   out_data.operation == rvdec_pkg::OP_SRLI ||
                   out_data.operation == rvdec_pkg::OP_SRAI))
    |-> (out_data.immediate[31:5] == '0))
    else $error("shift amount wider than five bits");

  // FENCE and system calls report no registers and no immediate.
  a_fence_sys_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.operation == rvdec_pkg::OP_FENCE ||
                   out_data.operation == rvdec_pkg::OP_ECALL ||
                   out_data.operation == rvdec_pkg::OP_EBREAK))
    |-> (out_data.dest_reg == '0 && out_data.src_reg_a == '0 &&
         out_data.src_reg_b == '0 && out_data.immediate == '0))
    else $error("fence or system result with nonzero fields");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for rv32i_instruction_decoder: directed and random
// instruction words against an in-bench decode predictor. Depends on rvdec_pkg.
`timescale 1ns / 1ps

module tb_top;

  // This limit only catches a hang; a normal run ends well within it.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 1300;
  // Every word issued after this point goes out back to back.
  localparam int DRAIN_TAIL = 200;
  // Lines printed for mismatches are capped. Every mismatch is still counted.
  localparam int PRINT_CAP = 60;

  // funct fields that no RV32I instruction of the group uses.
  localparam logic [2:0]  F3_NO_BRANCH = 3'b010;
  localparam logic [2:0]  F3_NO_LOAD   = 3'b011;
  localparam logic [2:0]  F3_NO_STORE  = 3'b111;
  localparam logic [6:0]  F7_BAD       = 7'h01;
  localparam logic [11:0] SYS_UNKNOWN  = 12'h302;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  rvdec_pkg::in_word_t  in_data;
  logic                 out_valid;
  rvdec_pkg::out_word_t out_data;

  // Words accepted by the decoder whose result has not come back yet, oldest first.
  rvdec_pkg::out_word_t pending_decodes[$];
  int unsigned          words_issued;
  int unsigned          directed_words;
  int unsigned          results_checked;
  int unsigned          mismatches;
  int unsigned          cycle_count;
  logic [40:0]          ops_seen;
  // When this is set, the sender idles in random bursts between words.
  bit                   gaps_on;

  rv32i_instruction_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decode predictor. It works out the expected result word for one input word.
  // Register fields start out as the raw bit fields. Each format then clears the
  // fields it does not use. The operation stays ILLEGAL unless a legal encoding
  // matches.
  function automatic rvdec_pkg::out_word_t decode_instr(rvdec_pkg::in_word_t iw);
    logic [31:0]          w;
    logic [2:0]           f3;
    logic [6:0]           f7;
    logic [31:0]          imm_i;
    rvdec_pkg::out_word_t d;
    w     = iw.instr_word;
    f3    = w[14:12];
    f7    = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    d.operation  = rvdec_pkg::OP_ILLEGAL;
    d.dest_reg   = w[11:7];
    d.src_reg_a  = w[19:15];
    d.src_reg_b  = w[24:20];
    d.immediate  = '0;
    d.instr_echo = w;
    d.addr_echo  = iw.fetch_address;
    case (w[6:0])
      rvdec_pkg::MAJOR_LUI, rvdec_pkg::MAJOR_AUIPC: begin
        d.operation = (w[6:0] == rvdec_pkg::MAJOR_LUI) ? rvdec_pkg::OP_LUI
                                                       : rvdec_pkg::OP_AUIPC;
        d.immediate = {w[31:12], 12'b0};
        d.src_reg_a = '0;
        d.src_reg_b = '0;
      end
      rvdec_pkg::MAJOR_JAL: begin
        d.operation = rvdec_pkg::OP_JAL;
        d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        d.src_reg_a = '0;
        d.src_reg_b = '0;
      end
      rvdec_pkg::MAJOR_JALR: begin
        // A bad funct3 leaves the raw register fields and a zero immediate.
        if (f3 == rvdec_pkg::F3_JALR) begin
          d.operation = rvdec_pkg::OP_JALR;
          d.immediate = imm_i;
          d.src_reg_b = '0;
        end
      end
      rvdec_pkg::MAJOR_BRANCH: begin
        d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        d.dest_reg  = '0;
        case (f3)
          rvdec_pkg::F3_BEQ:  d.operation = rvdec_pkg::OP_BEQ;
          rvdec_pkg::F3_BNE:  d.operation = rvdec_pkg::OP_BNE;
          rvdec_pkg::F3_BLT:  d.operation = rvdec_pkg::OP_BLT;
          rvdec_pkg::F3_BGE:  d.operation = rvdec_pkg::OP_BGE;
          rvdec_pkg::F3_BLTU: d.operation = rvdec_pkg::OP_BLTU;
          rvdec_pkg::F3_BGEU: d.operation = rvdec_pkg::OP_BGEU;
          default: ;
        endcase
      end
      rvdec_pkg::MAJOR_LOAD: begin
        d.immediate = imm_i;
        d.src_reg_b = '0;
        case (f3)
          rvdec_pkg::F3_B:  d.operation = rvdec_pkg::OP_LB;
          rvdec_pkg::F3_H:  d.operation = rvdec_pkg::OP_LH;
          rvdec_pkg::F3_W:  d.operation = rvdec_pkg::OP_LW;
          rvdec_pkg::F3_BU: d.operation = rvdec_pkg::OP_LBU;
          rvdec_pkg::F3_HU: d.operation = rvdec_pkg::OP_LHU;
          default: ;
        endcase
      end
      rvdec_pkg::MAJOR_STORE: begin
        d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        d.dest_reg  = '0;
        case (f3)
          rvdec_pkg::F3_B: d.operation = rvdec_pkg::OP_SB;
          rvdec_pkg::F3_H: d.operation = rvdec_pkg::OP_SH;
          rvdec_pkg::F3_W: d.operation = rvdec_pkg::OP_SW;
          default: ;
        endcase
      end
      rvdec_pkg::MAJOR_OP_IMM: begin
        // A shift with a bad upper field keeps the full I immediate.
        d.immediate = imm_i;
        d.src_reg_b = '0;
        case (f3)
          rvdec_pkg::F3_ADD:  d.operation = rvdec_pkg::OP_ADDI;
          rvdec_pkg::F3_SLT:  d.operation = rvdec_pkg::OP_SLTI;
          rvdec_pkg::F3_SLTU: d.operation = rvdec_pkg::OP_SLTIU;
          rvdec_pkg::F3_XOR:  d.operation = rvdec_pkg::OP_XORI;
          rvdec_pkg::F3_OR:   d.operation = rvdec_pkg::OP_ORI;
          rvdec_pkg::F3_AND:  d.operation = rvdec_pkg::OP_ANDI;
          rvdec_pkg::F3_SLL: begin
            if (f7 == rvdec_pkg::F7_NORMAL) begin
              d.operation = rvdec_pkg::OP_SLLI;
              d.immediate = {27'b0, w[24:20]};
            end
          end
          default: begin
            if (f7 == rvdec_pkg::F7_NORMAL || f7 == rvdec_pkg::F7_ALTERNATE) begin
              d.operation = (f7 == rvdec_pkg::F7_NORMAL) ? rvdec_pkg::OP_SRLI
                                                         : rvdec_pkg::OP_SRAI;
              d.immediate = {27'b0, w[24:20]};
            end
          end
        endcase
      end
      rvdec_pkg::MAJOR_OP: begin
        if (f7 == rvdec_pkg::F7_NORMAL) begin
          case (f3)
            rvdec_pkg::F3_ADD:  d.operation = rvdec_pkg::OP_ADD;
            rvdec_pkg::F3_SLL:  d.operation = rvdec_pkg::OP_SLL;
            rvdec_pkg::F3_SLT:  d.operation = rvdec_pkg::OP_SLT;
            rvdec_pkg::F3_SLTU: d.operation = rvdec_pkg::OP_SLTU;
            rvdec_pkg::F3_XOR:  d.operation = rvdec_pkg::OP_XOR;
            rvdec_pkg::F3_SR:   d.operation = rvdec_pkg::OP_SRL;
            rvdec_pkg::F3_OR:   d.operation = rvdec_pkg::OP_OR;
            default:            d.operation = rvdec_pkg::OP_AND;
          endcase
        end else if (f7 == rvdec_pkg::F7_ALTERNATE && f3 == rvdec_pkg::F3_ADD) begin
          d.operation = rvdec_pkg::OP_SUB;
        end else if (f7 == rvdec_pkg::F7_ALTERNATE && f3 == rvdec_pkg::F3_SR) begin
          d.operation = rvdec_pkg::OP_SRA;
        end
      end
      rvdec_pkg::MAJOR_FENCE: begin
        // Every other bit is ignored.
        d.operation = rvdec_pkg::OP_FENCE;
        d.dest_reg  = '0;
        d.src_reg_a = '0;
        d.src_reg_b = '0;
      end
      rvdec_pkg::MAJOR_SYSTEM: begin
        // Only bits 31:20 select the operation. The register fields are
        // cleared whatever that selection gives.
        d.dest_reg  = '0;
        d.src_reg_a = '0;
        d.src_reg_b = '0;
        if (w[31:20] == rvdec_pkg::SYS_ECALL) begin
          d.operation = rvdec_pkg::OP_ECALL;
        end else if (w[31:20] == rvdec_pkg::SYS_EBREAK) begin
          d.operation = rvdec_pkg::OP_EBREAK;
        end
      end
      default: ;
    endcase
    return d;
  endfunction

  // Builds a legal encoding of one operation. The bits that are free are taken
  // from fill. ILLEGAL becomes an unknown major opcode: bit 1 is cleared, and
  // every RV32I major opcode has that bit set.
  function automatic logic [31:0] encode_op(logic [5:0] op, logic [31:0] fill);
    logic [31:0] w;
    w = fill;
    case (op)
      rvdec_pkg::OP_ADD:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_ADD, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_SUB:
        w = {rvdec_pkg::F7_ALTERNATE, fill[24:15], rvdec_pkg::F3_ADD, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_SLL:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_SLL, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_SRL:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_SR, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_SRA:
        w = {rvdec_pkg::F7_ALTERNATE, fill[24:15], rvdec_pkg::F3_SR, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_SLT:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_SLT, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_SLTU:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_SLTU, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_AND:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_AND, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_OR:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_OR, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_XOR:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_XOR, fill[11:7],
             rvdec_pkg::MAJOR_OP};
      rvdec_pkg::OP_ADDI:
        w = {fill[31:15], rvdec_pkg::F3_ADD, fill[11:7], rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_SLLI:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_SLL, fill[11:7],
             rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_SRLI:
        w = {rvdec_pkg::F7_NORMAL, fill[24:15], rvdec_pkg::F3_SR, fill[11:7],
             rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_SRAI:
        w = {rvdec_pkg::F7_ALTERNATE, fill[24:15], rvdec_pkg::F3_SR, fill[11:7],
             rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_SLTI:
        w = {fill[31:15], rvdec_pkg::F3_SLT, fill[11:7], rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_SLTIU:
        w = {fill[31:15], rvdec_pkg::F3_SLTU, fill[11:7], rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_ANDI:
        w = {fill[31:15], rvdec_pkg::F3_AND, fill[11:7], rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_ORI:
        w = {fill[31:15], rvdec_pkg::F3_OR, fill[11:7], rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_XORI:
        w = {fill[31:15], rvdec_pkg::F3_XOR, fill[11:7], rvdec_pkg::MAJOR_OP_IMM};
      rvdec_pkg::OP_LB:
        w = {fill[31:15], rvdec_pkg::F3_B, fill[11:7], rvdec_pkg::MAJOR_LOAD};
      rvdec_pkg::OP_LH:
        w = {fill[31:15], rvdec_pkg::F3_H, fill[11:7], rvdec_pkg::MAJOR_LOAD};
      rvdec_pkg::OP_LW:
        w = {fill[31:15], rvdec_pkg::F3_W, fill[11:7], rvdec_pkg::MAJOR_LOAD};
      rvdec_pkg::OP_LBU:
        w = {fill[31:15], rvdec_pkg::F3_BU, fill[11:7], rvdec_pkg::MAJOR_LOAD};
      rvdec_pkg::OP_LHU:
        w = {fill[31:15], rvdec_pkg::F3_HU, fill[11:7], rvdec_pkg::MAJOR_LOAD};
      rvdec_pkg::OP_SB:
        w = {fill[31:15], rvdec_pkg::F3_B, fill[11:7], rvdec_pkg::MAJOR_STORE};
      rvdec_pkg::OP_SH:
        w = {fill[31:15], rvdec_pkg::F3_H, fill[11:7], rvdec_pkg::MAJOR_STORE};
      rvdec_pkg::OP_SW:
        w = {fill[31:15], rvdec_pkg::F3_W, fill[11:7], rvdec_pkg::MAJOR_STORE};
      rvdec_pkg::OP_BEQ:
        w = {fill[31:15], rvdec_pkg::F3_BEQ, fill[11:7], rvdec_pkg::MAJOR_BRANCH};
      rvdec_pkg::OP_BNE:
        w = {fill[31:15], rvdec_pkg::F3_BNE, fill[11:7], rvdec_pkg::MAJOR_BRANCH};
      rvdec_pkg::OP_BLT:
        w = {fill[31:15], rvdec_pkg::F3_BLT, fill[11:7], rvdec_pkg::MAJOR_BRANCH};
      rvdec_pkg::OP_BGE:
        w = {fill[31:15], rvdec_pkg::F3_BGE, fill[11:7], rvdec_pkg::MAJOR_BRANCH};
      rvdec_pkg::OP_BLTU:
        w = {fill[31:15], rvdec_pkg::F3_BLTU, fill[11:7], rvdec_pkg::MAJOR_BRANCH};
      rvdec_pkg::OP_BGEU:
        w = {fill[31:15], rvdec_pkg::F3_BGEU, fill[11:7], rvdec_pkg::MAJOR_BRANCH};
      rvdec_pkg::OP_JAL:
        w = {fill[31:7], rvdec_pkg::MAJOR_JAL};
      rvdec_pkg::OP_JALR:
        w = {fill[31:15], rvdec_pkg::F3_JALR, fill[11:7], rvdec_pkg::MAJOR_JALR};
      rvdec_pkg::OP_LUI:
        w = {fill[31:7], rvdec_pkg::MAJOR_LUI};
      rvdec_pkg::OP_AUIPC:
        w = {fill[31:7], rvdec_pkg::MAJOR_AUIPC};
      rvdec_pkg::OP_ECALL:
        w = {rvdec_pkg::SYS_ECALL, fill[19:7], rvdec_pkg::MAJOR_SYSTEM};
      rvdec_pkg::OP_EBREAK:
        w = {rvdec_pkg::SYS_EBREAK, fill[19:7], rvdec_pkg::MAJOR_SYSTEM};
      rvdec_pkg::OP_FENCE:
        w = {fill[31:7], rvdec_pkg::MAJOR_FENCE};
      default:
        w = {fill[31:2], 1'b0, fill[0]};
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] instr, logic [31:0] got,
                                 logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("ERROR %s: instr %h got %h expected %h", what, instr, got, want);
    end
  endtask

  // Sends one word, with an optional idle burst before it. The task returns at
  // the clock edge that accepts the word. It lowers start only when it idles, so
  // back-to-back words never drop start for a cycle.
  task automatic issue_word(logic [31:0] instr, logic [31:0] addr);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_data <= '{instr_word: instr, fetch_address: addr};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_issued++;
  endtask

  // Words are accepted and results come back at rising edges. Both are sampled
  // here, before any nonblocking update of that edge takes effect. The expected
  // result is queued at acceptance, and each result strobe is checked against
  // the oldest expectation.
  always @(posedge clk) begin : result_check
    rvdec_pkg::out_word_t want;
    if (rst_n) begin
      if (start && !busy) begin
        pending_decodes.push_back(decode_instr(in_data));
      end
      if (out_valid) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("unexpected result", out_data.instr_echo,
                          32'(out_data.operation), '0);
        end else begin
          want = pending_decodes.pop_front();
          results_checked++;
          if (out_data.operation <= rvdec_pkg::OP_ILLEGAL)
            ops_seen[out_data.operation] = 1'b1;
          if (out_data.operation !== want.operation)
            report_mismatch("operation", want.instr_echo, 32'(out_data.operation),
                            32'(want.operation));
          if (out_data.dest_reg !== want.dest_reg)
            report_mismatch("dest_reg", want.instr_echo, 32'(out_data.dest_reg),
                            32'(want.dest_reg));
          if (out_data.src_reg_a !== want.src_reg_a)
            report_mismatch("src_reg_a", want.instr_echo, 32'(out_data.src_reg_a),
                            32'(want.src_reg_a));
          if (out_data.src_reg_b !== want.src_reg_b)
            report_mismatch("src_reg_b", want.instr_echo, 32'(out_data.src_reg_b),
                            32'(want.src_reg_b));
          if (out_data.immediate !== want.immediate)
            report_mismatch("immediate", want.instr_echo, out_data.immediate, want.immediate);
          if (out_data.instr_echo !== want.instr_echo)
            report_mismatch("instr_echo", want.instr_echo, out_data.instr_echo,
                            want.instr_echo);
          if (out_data.addr_echo !== want.addr_echo)
            report_mismatch("addr_echo", want.instr_echo, out_data.addr_echo, want.addr_echo);
        end
      end
    end
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ERROR timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_decodes.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Every operation once. The free fields alternate between all ones and all
  // zeros, and so do the fetch addresses. This sets every immediate field to all
  // ones or all zeros, and reaches the largest shift amount.
  task automatic test_every_operation();
    logic [31:0] fill;
    for (int k = 0; k <= int'(rvdec_pkg::OP_ILLEGAL); k++) begin
      fill = (k % 2 == 0) ? '1 : '0;
      issue_word(encode_op(6'(k), fill), fill);
    end
  endtask

  // Encodings at the edges of each group: bad function fields, unknown opcodes,
  // and the don't-care bits of FENCE and SYSTEM.
  task automatic test_special_cases();
    logic [31:0] r;
    r = $urandom();
    issue_word('1, '1);
    issue_word('0, '0);
    issue_word({r[31:15], F3_NO_STORE, r[11:7], rvdec_pkg::MAJOR_JALR}, r);
    issue_word({r[31:15], F3_NO_BRANCH, r[11:7], rvdec_pkg::MAJOR_BRANCH}, r);
    issue_word({r[31:15], F3_NO_LOAD, r[11:7], rvdec_pkg::MAJOR_BRANCH}, r);
    issue_word({r[31:15], F3_NO_LOAD, r[11:7], rvdec_pkg::MAJOR_LOAD}, r);
    issue_word({r[31:15], F3_NO_STORE, r[11:7], rvdec_pkg::MAJOR_LOAD}, r);
    issue_word({r[31:15], rvdec_pkg::F3_BU, r[11:7], rvdec_pkg::MAJOR_STORE}, r);
    // A shift immediate with a bad upper field keeps the full 12-bit immediate.
    issue_word({rvdec_pkg::F7_ALTERNATE, r[24:15], rvdec_pkg::F3_SLL, r[11:7],
                rvdec_pkg::MAJOR_OP_IMM}, r);
    issue_word({7'h7f, r[24:15], rvdec_pkg::F3_SR, r[11:7], rvdec_pkg::MAJOR_OP_IMM}, r);
    issue_word({F7_BAD, r[24:15], rvdec_pkg::F3_ADD, r[11:7], rvdec_pkg::MAJOR_OP}, r);
    issue_word({rvdec_pkg::F7_ALTERNATE, r[24:15], rvdec_pkg::F3_SLL, r[11:7],
                rvdec_pkg::MAJOR_OP}, r);
    issue_word({25'h1ffffff, rvdec_pkg::MAJOR_FENCE}, r);
    issue_word({SYS_UNKNOWN, r[19:7], rvdec_pkg::MAJOR_SYSTEM}, r);
    issue_word({rvdec_pkg::SYS_ECALL, 13'h1fff, rvdec_pkg::MAJOR_SYSTEM}, r);
  endtask

  // Random words. Most of them are legal encodings of a random operation with
  // random fields. Some are legal encodings with a corrupted funct3 or funct7,
  // and the rest are fully random words. Idle bursts come and go in stretches of
  // 64 words. The tail of the run goes back to back.
  task automatic test_random_stream(int n);
    int unsigned pick;
    logic [31:0] w;
    logic [31:0] addr;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (i >= n - DRAIN_TAIL) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      w = encode_op(6'($urandom_range(0, int'(rvdec_pkg::OP_ILLEGAL))), $urandom());
      if (pick >= 70 && pick < 88) begin
        if ($urandom_range(0, 1) == 1) w[31:25] = 7'($urandom());
        else w[14:12] = 3'($urandom());
      end else if (pick >= 88) begin
        w = $urandom();
      end
      addr = $urandom();
      if ($urandom_range(0, 15) == 0) addr = ($urandom_range(0, 1) == 1) ? '1 : '0;
      issue_word(w, addr);
    end
  endtask

  initial begin
    words_issued    = 0;
    directed_words  = 0;
    results_checked = 0;
    mismatches      = 0;
    cycle_count     = 0;
    ops_seen        = '0;
    gaps_on         = 1'b1;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_every_operation();
    test_special_cases();
    directed_words = words_issued;
    test_random_stream(RANDOM_WORDS);
    start <= 1'b0;

    // Drain. The watchdog bounds this wait. The idle wait after it catches any
    // stray result strobe from the decoder's input and result registers.
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (pending_decodes.size() != 0) begin
      report_mismatch("missing result", pending_decodes[0].instr_echo, '0, '0);
      void'(pending_decodes.pop_front());
    end

    $display("Issued %0d instruction words (%0d directed), checked %0d decoded results.",
             words_issued, directed_words, results_checked);
    $display("Saw %0d of 41 operation codes including ILLEGAL; %0d field mismatches.",
             $countones(ops_seen), mismatches);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
